[rtl/core/psu_pkg.sv]
package psu_pkg;

  // Filter types of a scanline.
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;
  localparam logic [7:0] FILT_MAX   = 8'd4;

  // Configuration register indexes.
  localparam logic REG_ROW_BYTES = 1'b0;
  localparam logic REG_BPP       = 1'b1;

  localparam int ROW_BYTES_W = 13;
  localparam int BPP_W       = 3;

  // Sample command from the front part to the back part.
  typedef struct packed {
    logic [7:0] data;
    logic       first_row;
    logic [2:0] filt;
    logic       bad;
    logic       last;
    logic       row_start;
  } cmd_t;

  // One result byte.
  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
    logic       err;
  } res_t;

endpackage

[rtl/core/psu_ram.sv]
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/psu_fifo.sv]
module psu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/core/psu_front.sv]
module psu_front #(
  parameter int MAX_ROW_BYTES = 4096,
  parameter int CW            = 13
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic                                q_full,
  input  logic [7:0]                          data_byte,
  input  logic                                image_start,
  input  logic [psu_pkg::ROW_BYTES_W-1:0]     row_bytes,
  output logic                                q_push,
  output psu_pkg::cmd_t                       cmd,
  output logic [CW-1:0]                       col
);

  logic            await_r, await_nxt;
  logic            first_r, first_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [2:0]      filt_r, filt_nxt;
  logic            bad_r, bad_nxt;
  logic            accept, is_hdr, hdr_bad, last;
  logic [CW-1:0]   len;
  logic [CW:0]     col_inc;

  assign accept  = push & ~q_full;
  assign is_hdr  = image_start | await_r;
  assign hdr_bad = (data_byte > psu_pkg::FILT_MAX);

  // Clamp the row length into 1..MAX_ROW_BYTES.
  always_comb begin
    if (row_bytes == '0) begin
      len = CW'(1);
    end else if (32'(row_bytes) > 32'(MAX_ROW_BYTES)) begin
      len = CW'(MAX_ROW_BYTES);
    end else begin
      len = CW'(row_bytes);
    end
  end

  assign col_inc = {1'b0, col_r} + 1'b1;
  assign last    = (col_inc >= {1'b0, len});

  assign q_push        = accept & ~is_hdr;
  assign col           = col_r;
  assign cmd.data      = data_byte;
  assign cmd.first_row = first_r;
  assign cmd.filt      = filt_r;
  assign cmd.bad       = bad_r;
  assign cmd.last      = last;
  assign cmd.row_start = (col_r == '0);

  always_comb begin
    await_nxt = await_r;
    first_nxt = first_r;
    col_nxt   = col_r;
    filt_nxt  = filt_r;
    bad_nxt   = bad_r;
    if (accept) begin
      if (is_hdr) begin
        // Filter-type byte: latch the row's filter, drop the byte.
        bad_nxt   = hdr_bad;
        filt_nxt  = hdr_bad ? psu_pkg::FILT_NONE : data_byte[2:0];
        col_nxt   = '0;
        await_nxt = 1'b0;
        first_nxt = image_start | first_r;
      end else if (last) begin
        col_nxt   = '0;
        await_nxt = 1'b1;
        first_nxt = 1'b0;
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b1;
      first_r <= 1'b1;
      col_r   <= '0;
      filt_r  <= psu_pkg::FILT_NONE;
      bad_r   <= 1'b0;
    end else begin
      await_r <= await_nxt;
      first_r <= first_nxt;
      col_r   <= col_nxt;
      filt_r  <= filt_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

[rtl/core/psu_back.sv]
module psu_back #(
  parameter int CW = 13,
  parameter int AW = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  psu_pkg::cmd_t               q_cmd,
  input  logic [CW-1:0]               q_col,
  output logic                        q_pop,
  input  logic [psu_pkg::BPP_W-1:0]   bpp,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [7:0]                  ram_wdata,
  output logic                        ram_re,
  output logic [AW-1:0]               ram_raddr,
  input  logic [7:0]                  ram_rdata,
  input  logic                        oq_full,
  output logic                        oq_push,
  output psu_pkg::res_t               res
);

  logic                 rd_vld_r, rd_vld_nxt;
  psu_pkg::cmd_t        rd_cmd_r;
  logic [AW-1:0]        rd_addr_r;
  logic                 byp_r;
  logic [7:0]           byp_data_r;
  logic [31:0]          lh_r, uh_r;
  logic [31:0]          lh_eff, uh_eff;
  logic                 fire, load;
  logic [7:0]           a, b, c, pred, r;
  logic [8:0]           ab_sum;
  logic signed [9:0]    da, db, dc;
  logic [9:0]           pa, pb, pc;

  assign fire = rd_vld_r & ~oq_full;
  assign load = ~q_empty & (~rd_vld_r | fire);

  assign lh_eff = rd_cmd_r.row_start ? '0 : lh_r;
  assign uh_eff = rd_cmd_r.row_start ? '0 : uh_r;

  always_comb begin
    unique case (bpp)
      3'd0, 3'd1: begin
        a = lh_eff[7:0];
        c = uh_eff[7:0];
      end
      3'd2: begin
        a = lh_eff[15:8];
        c = uh_eff[15:8];
      end
      3'd3: begin
        a = lh_eff[23:16];
        c = uh_eff[23:16];
      end
      default: begin
        a = lh_eff[31:24];
        c = uh_eff[31:24];
      end
    endcase
  end

  // Line store word or the byte written at its read; zero in the first row.
  assign b = rd_cmd_r.first_row ? 8'd0 : (byp_r ? byp_data_r : ram_rdata);

  assign ab_sum = {1'b0, a} + {1'b0, b};
  assign da = $signed({2'b00, b}) - $signed({2'b00, c});
  assign db = $signed({2'b00, a}) - $signed({2'b00, c});
  assign dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
  assign pa = da[9] ? 10'(-da) : 10'(da);
  assign pb = db[9] ? 10'(-db) : 10'(db);
  assign pc = dc[9] ? 10'(-dc) : 10'(dc);

  always_comb begin
    unique case (rd_cmd_r.filt)
      psu_pkg::FILT_SUB: pred = a;
      psu_pkg::FILT_UP:  pred = b;
      psu_pkg::FILT_AVG: pred = ab_sum[8:1];
      psu_pkg::FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default: pred = 8'd0;
    endcase
  end

  assign r = rd_cmd_r.data + pred;

  assign q_pop     = load;
  assign ram_re    = load;
  assign ram_raddr = q_col[AW-1:0];
  assign ram_we    = fire;
  assign ram_waddr = rd_addr_r;
  assign ram_wdata = r;
  assign oq_push   = fire;
  assign res.pixel = r;
  assign res.last  = rd_cmd_r.last;
  assign res.err   = rd_cmd_r.bad;

  assign rd_vld_nxt = load | (rd_vld_r & ~fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rd_cmd_r   <= q_cmd;
      rd_addr_r  <= q_col[AW-1:0];
      byp_r      <= fire && (rd_addr_r == q_col[AW-1:0]);
      byp_data_r <= r;
    end
    if (fire) begin
      lh_r <= {lh_eff[23:0], r};
      uh_r <= {uh_eff[23:0], b};
    end
  end

endmodule

[rtl/core/png_scanline_unfilter.sv]
// Channel   Handshake             Payload
// input     push / full           in_data_byte, in_image_start
// result    empty / pop           out_pixel_byte, out_row_last, out_filter_error
// config    psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// One byte per cycle sustained while the result queue is not full; a sample byte goes
// through the command queue and the line store read before it enters the result queue.
// The back part's line store read sets the pace: one read, one write a cycle unless stalled.
// Filter-type bytes are absorbed by the front part and give no result.
// Reset (rst_n low, synchronous) empties both queues; the line store has no clear.
// A full result queue stalls the back part; the command queue then fills and raises full.
module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_image_start,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_pixel_byte,
  output logic        out_row_last,
  output logic        out_filter_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW   = $clog2(MAX_ROW_BYTES + 1);
  localparam int AW   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int CMDW = $bits(psu_pkg::cmd_t) + CW;

  logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes_r;
  logic [psu_pkg::BPP_W-1:0]       bpp_r;
  logic                            cfg_wr;

  psu_pkg::cmd_t   f_cmd, q_cmd;
  logic [CW-1:0]   f_col, q_col;
  logic            cmdq_push, cmdq_full, cmdq_pop, cmdq_empty;
  logic [CMDW-1:0] cmdq_rdata;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;

  logic            oq_push, oq_full;
  psu_pkg::res_t   b_res, o_res;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= psu_pkg::ROW_BYTES_W'(1);
      bpp_r       <= psu_pkg::BPP_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        psu_pkg::REG_ROW_BYTES: row_bytes_r <= pwdata[psu_pkg::ROW_BYTES_W-1:0];
        psu_pkg::REG_BPP:       bpp_r       <= pwdata[psu_pkg::BPP_W-1:0];
        default:                ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      psu_pkg::REG_ROW_BYTES: prdata = 32'(row_bytes_r);
      psu_pkg::REG_BPP:       prdata = 32'(bpp_r);
      default:                prdata = '0;
    endcase
  end

  psu_front #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .CW           (CW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .q_full     (cmdq_full),
    .data_byte  (in_data_byte),
    .image_start(in_image_start),
    .row_bytes  (row_bytes_r),
    .q_push     (cmdq_push),
    .cmd        (f_cmd),
    .col        (f_col)
  );

  assign full = cmdq_full;

  psu_fifo #(
    .WIDTH(CMDW),
    .DEPTH(2)
  ) u_cmdq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmdq_push),
    .wdata({f_cmd, f_col}),
    .full (cmdq_full),
    .pop  (cmdq_pop),
    .rdata(cmdq_rdata),
    .empty(cmdq_empty)
  );

  assign q_cmd = psu_pkg::cmd_t'(cmdq_rdata[CMDW-1:CW]);
  assign q_col = cmdq_rdata[CW-1:0];

  psu_back #(
    .CW(CW),
    .AW(AW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (cmdq_empty),
    .q_cmd    (q_cmd),
    .q_col    (q_col),
    .q_pop    (cmdq_pop),
    .bpp      (bpp_r),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .res      (b_res)
  );

  psu_ram #(
    .WIDTH(8),
    .DEPTH(MAX_ROW_BYTES)
  ) u_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  psu_fifo #(
    .WIDTH($bits(psu_pkg::res_t)),
    .DEPTH(2)
  ) u_outq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (oq_push),
    .wdata(b_res),
    .full (oq_full),
    .pop  (pop),
    .rdata(o_res),
    .empty(empty)
  );

  assign out_pixel_byte   = o_res.pixel;
  assign out_row_last     = o_res.last;
  assign out_filter_error = o_res.err;

  a_cmdq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmdq_push |-> !cmdq_full)
    else $error("command queue written while full");

  a_outq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> !oq_full)
    else $error("result queue written while full");

  a_start_gives_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && in_image_start) |-> !cmdq_push)
    else $error("filter-type byte at image start entered the command queue");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LINE      = 4096;
  localparam int N_STEPS       = 29;
  localparam int N_PHASES      = 12;
  localparam int N_PHASE_ITEMS = 52;
  localparam psu_pkg::res_t NO_RES = '0;

  // One row of the directed plan: either a register write or one input byte.
  typedef struct packed {
    logic          is_reg;
    logic          idx;
    logic [31:0]   val;
    logic [7:0]    data;
    logic          start;
    logic          typed;
    psu_pkg::res_t want;
  } step_t;

  typedef enum logic [1:0] {POP_ALWAYS, POP_COIN, POP_TRICKLE, POP_MOSTLY} pop_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        in_image_start = 1'b0;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire         full;
  wire         empty;
  wire  [7:0]  out_pixel_byte;
  wire         out_row_last;
  wire         out_filter_error;
  wire  [31:0] prdata;
  wire         pready;

  png_scanline_unfilter #(.MAX_ROW_BYTES(MAX_LINE)) u_dut (
    .clk, .rst_n, .push, .full, .in_data_byte, .in_image_start,
    .empty, .pop, .out_pixel_byte, .out_row_last, .out_filter_error,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk = ~clk;

  // Scanline reconstruction state mirrored by the testbench.
  logic [7:0]  line_mem [MAX_LINE];
  logic [31:0] left_hist = '0;
  logic [31:0] upleft_hist = '0;
  int unsigned col_pos = 0;
  logic [2:0]  row_type = psu_pkg::FILT_NONE;
  bit          want_type = 1'b1;
  bit          first_line = 1'b1;
  bit          bad_type = 1'b0;
  logic [12:0] reg_row_bytes = 13'd1;
  logic [2:0]  reg_bpp = 3'd1;

  psu_pkg::res_t expected_px [$];
  int          burst_left = 0;
  int          n_fail = 0;
  int          n_checked = 0;
  int          n_pushed = 0;
  int          n_reg_writes = 0;
  pop_mode_t   pop_mode = POP_ALWAYS;
  int          pop_mode_left = 0;

  function automatic int unsigned line_len(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_LINE) return MAX_LINE;
    return 32'(v);
  endfunction

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int p, pa, pb, pc;
    p  = int'(a) + int'(b) - int'(c);
    pa = p - int'(a);
    pb = p - int'(b);
    pc = p - int'(c);
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // Advance the mirrored state by one accepted byte; return 1 with the pixel it yields.
  function automatic bit predict_byte(input logic [7:0] x, input logic s,
                                      output psu_pkg::res_t r);
    int unsigned len, bpp, col;
    logic [7:0]  a, b, c, pred;
    logic [8:0]  sum;
    r = NO_RES;
    if (s) begin
      first_line = 1'b1;
      want_type  = 1'b1;
    end
    if (want_type) begin
      bad_type    = x > psu_pkg::FILT_MAX;
      row_type    = bad_type ? psu_pkg::FILT_NONE : x[2:0];
      col_pos     = 0;
      left_hist   = '0;
      upleft_hist = '0;
      want_type   = 1'b0;
      return 1'b0;
    end
    len = line_len(reg_row_bytes);
    bpp = (reg_bpp == 0) ? 1 : (reg_bpp > 4) ? 4 : 32'(reg_bpp);
    col = (col_pos >= MAX_LINE) ? MAX_LINE - 1 : col_pos;
    a = 8'(left_hist >> (8 * (bpp - 1)));
    b = first_line ? 8'h00 : line_mem[col];
    c = 8'(upleft_hist >> (8 * (bpp - 1)));
    case (row_type)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG: begin
        sum  = {1'b0, a} + {1'b0, b};
        pred = sum[8:1];
      end
      psu_pkg::FILT_PAETH: pred = paeth_pick(a, b, c);
      default:             pred = 8'h00;
    endcase
    r.pixel       = x + pred;
    r.err         = bad_type;
    line_mem[col] = r.pixel;
    left_hist     = {left_hist[23:0], r.pixel};
    upleft_hist   = {upleft_hist[23:0], b};
    if (col + 1 >= len) begin
      r.last     = 1'b1;
      col_pos    = 0;
      want_type  = 1'b1;
      first_line = 1'b0;
    end else begin
      r.last  = 1'b0;
      col_pos = col + 1;
    end
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic s, input bit typed,
                           input psu_pkg::res_t want);
    int            gap;
    psu_pkg::res_t got;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0
            : $urandom_range(1, ($urandom_range(0, 9) == 0) ? 20 : 4);
      if (gap != 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                               : $urandom_range(1, 16);
    end
    @(negedge clk);
    push           <= 1'b1;
    in_data_byte   <= d;
    in_image_start <= s;
    do @(posedge clk); while (full !== 1'b0);
    burst_left--;
    n_pushed++;
    if (predict_byte(d, s, got)) expected_px.push_back(typed ? want : got);
  endtask

  // Drop push, drain every pending pixel and let the pipeline empty.
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    burst_left = 0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == psu_pkg::REG_ROW_BYTES) reg_row_bytes = val[12:0];
    else reg_bpp = val[2:0];
    n_reg_writes++;
  endtask

  // Result side: switch between pop patterns, one of them stall-free.
  always @(negedge clk) begin
    if (pop_mode_left == 0) begin
      pop_mode      = pop_mode_t'($urandom_range(0, 3));
      pop_mode_left = $urandom_range(8, 64);
    end
    pop_mode_left--;
    case (pop_mode)
      POP_ALWAYS:  pop <= 1'b1;
      POP_COIN:    pop <= 1'($urandom_range(0, 1));
      POP_TRICKLE: pop <= ($urandom_range(0, 7) == 0);
      default:     pop <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    psu_pkg::res_t exp_px;
    if (rst_n && pop === 1'b1 && empty === 1'b0) begin
      if (expected_px.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("%0t: unexpected pixel %02h last %0b err %0b", $realtime,
                   out_pixel_byte, out_row_last, out_filter_error);
      end else begin
        exp_px = expected_px.pop_front();
        n_checked++;
        if (out_pixel_byte !== exp_px.pixel || out_row_last !== exp_px.last ||
            out_filter_error !== exp_px.err) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: pixel %02h/%02h last %0b/%0b err %0b/%0b (expected/actual)",
                     $realtime, exp_px.pixel, out_pixel_byte, exp_px.last, out_row_last,
                     exp_px.err, out_filter_error);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    step_t       plan [N_STEPS];
    int unsigned ph_len  [N_PHASES];
    int unsigned ph_bpp  [N_PHASES];
    bit          grew;
    logic        start;
    logic [7:0]  data;
    int          pick;

    plan = '{
      // reset settings: one byte per row
      '{1'b0, 1'b0, 32'd0, {5'd0, psu_pkg::FILT_NONE}, 1'b1, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}},
      '{1'b0, 1'b0, 32'd0, psu_pkg::FILT_MAX + 8'd3, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'h80, 1'b0, 1'b1, '{8'h80, 1'b1, 1'b1}},
      '{1'b1, psu_pkg::REG_ROW_BYTES, 32'd3, 8'h00, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, {5'd0, psu_pkg::FILT_SUB}, 1'b1, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'h10, 1'b0, 1'b1, '{8'h10, 1'b0, 1'b0}},
      '{1'b0, 1'b0, 32'd0, 8'hF0, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{1'b0, 1'b0, 32'd0, 8'h05, 1'b0, 1'b1, '{8'h05, 1'b1, 1'b0}},
      '{1'b0, 1'b0, 32'd0, {5'd0, psu_pkg::FILT_UP}, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'h01, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'hFF, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'h80, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, {5'd0, psu_pkg::FILT_AVG}, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'h40, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'h7F, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'h00, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, {5'd0, psu_pkg::FILT_PAETH}, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'h33, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'hCC, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'h01, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'hFF, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1}},
      // new image in the middle of a row, then shrink the row under the column
      '{1'b0, 1'b0, 32'd0, {5'd0, psu_pkg::FILT_UP}, 1'b1, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'h55, 1'b0, 1'b1, '{8'h55, 1'b0, 1'b0}},
      '{1'b1, psu_pkg::REG_ROW_BYTES, 32'd1, 8'h00, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'hAA, 1'b0, 1'b1, '{8'hAA, 1'b1, 1'b0}},
      '{1'b0, 1'b0, 32'd0, {5'd0, psu_pkg::FILT_NONE}, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1'b0, 32'd0, 8'h7E, 1'b0, 1'b1, '{8'h7E, 1'b1, 1'b0}}
    };
    ph_len  = '{0, 2, 7, 1, 16, 8191, 5, 3, 12, 4096, 9, 6};
    ph_bpp  = '{0, 2, 7, 1, 4,  3,    5, 6, 2,  1,    4, 3};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_byte(plan[i].data, plan[i].start, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      grew = line_len(13'(ph_len[ph])) > line_len(reg_row_bytes);
      write_reg(psu_pkg::REG_ROW_BYTES, ph_len[ph]);
      write_reg(psu_pkg::REG_BPP, ph_bpp[ph]);
      for (int k = 0; k < N_PHASE_ITEMS; k++) begin
        // a longer row must not reach line store entries the last row never wrote
        start = (k == 0 && grew) || ($urandom_range(0, 99) < 3);
        pick  = $urandom_range(0, 99);
        if (want_type || start)
          data = (pick < 88) ? 8'($urandom_range(0, 4)) : 8'($urandom_range(5, 255));
        else if (pick < 10)
          data = 8'h00;
        else if (pick < 20)
          data = 8'hFF;
        else
          data = 8'($urandom_range(0, 255));
        send_byte(data, start, 1'b0, NO_RES);
      end
    end

    settle();
    $display("Pushed %0d bytes and checked %0d pixels over %0d register writes,",
             n_pushed, n_checked, n_reg_writes);
    $display("all five filters, bad filter types, oversized rows and mid-row changes included.");
    if (n_fail == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
